@@ rtl/core/assert_macros.svh @@
// Assertion helpers; expect clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every edge outside reset.
`define B91_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition implies consequence on the next edge.
`define B91_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/b91_pkg.sv @@
`default_nettype none
package b91_pkg;

	localparam int RADIX       = 91;
	localparam int RECIP       = 11523;  // ceil(2^20 / 91), exact for 14-bit values
	localparam int RECIP_SHIFT = 20;
	localparam int SMALL_LIMIT = 88;
	localparam int FLUSH_LIMIT = 90;
	localparam int TAKE_LIMIT  = 13;
	localparam int HALF_BITS   = 7;

	typedef logic [6:0] sym_t;

	// One queued beat of work: an optional pair and an optional flush.
	typedef struct packed {
		logic        pair;
		logic [13:0] v;
		sym_t        qv;
		logic        flush;
		logic        flush_div;
		logic [12:0] f;
		sym_t        qf;
		logic        last;
	} b91_job_t;

	function automatic logic [6:0] char_of(input sym_t sym);
		logic [6:0] c;
		c = 7'd126;
		if (sym < 7'd26) begin
			c = 7'(sym + 7'd65);
		end else if (sym < 7'd52) begin
			c = 7'(sym + 7'd71);
		end else if (sym < 7'd62) begin
			c = 7'(sym - 7'd4);
		end else begin
			case (sym)
				7'd62:   c = 7'd33;
				7'd63:   c = 7'd35;
				7'd64:   c = 7'd36;
				7'd65:   c = 7'd37;
				7'd66:   c = 7'd38;
				7'd67:   c = 7'd40;
				7'd68:   c = 7'd41;
				7'd69:   c = 7'd42;
				7'd70:   c = 7'd43;
				7'd71:   c = 7'd44;
				7'd72:   c = 7'd45;
				7'd73:   c = 7'd46;
				7'd74:   c = 7'd47;
				7'd75:   c = 7'd58;
				7'd76:   c = 7'd59;
				7'd77:   c = 7'd60;
				7'd78:   c = 7'd61;
				7'd79:   c = 7'd62;
				7'd80:   c = 7'd63;
				7'd81:   c = 7'd64;
				7'd82:   c = 7'd91;
				7'd83:   c = 7'd93;
				7'd84:   c = 7'd94;
				7'd85:   c = 7'd95;
				7'd86:   c = 7'd96;
				7'd87:   c = 7'd123;
				7'd88:   c = 7'd124;
				7'd89:   c = 7'd125;
				default: c = 7'd126;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/b91_if.sv @@
`default_nettype none
interface b91_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b91_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ rtl/core/b91_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module b91_front (
	input  wire               clk,
	input  wire               arst_n,
	b91_byte_if.sink          bytes,
	input  wire               full,
	output logic              push,
	output b91_pkg::b91_job_t job
);

	logic [12:0] store_q;
	logic [3:0]  cnt_q;

	logic [20:0] acc;
	logic [4:0]  cnt8;
	logic        take;
	logic        use13;
	logic [20:0] shifted;
	logic [12:0] rest;
	logic [4:0]  cnt_rest;
	logic [27:0] prod_v;
	logic [26:0] prod_f;
	logic        accept;

	always_comb begin
		acc      = {8'd0, store_q} | (21'(bytes.data_byte) << cnt_q);
		cnt8     = 5'(cnt_q) + 5'd8;
		take     = cnt8 > 5'(b91_pkg::TAKE_LIMIT);
		use13    = acc[12:0] > 13'(b91_pkg::SMALL_LIMIT);
		shifted  = use13 ? (acc >> 13) : (acc >> 14);
		rest     = take ? shifted[12:0] : acc[12:0];
		cnt_rest = take ? (use13 ? cnt8 - 5'd13 : cnt8 - 5'd14) : cnt8;

		job.pair      = take;
		job.v         = use13 ? {1'b0, acc[12:0]} : acc[13:0];
		prod_v        = 28'(job.v) * 28'(b91_pkg::RECIP);
		job.qv        = prod_v[b91_pkg::RECIP_SHIFT +: 7];
		job.f         = rest;
		prod_f        = 27'(rest) * 27'(b91_pkg::RECIP);
		job.qf        = prod_f[b91_pkg::RECIP_SHIFT +: 7];
		job.last      = bytes.last_byte;
		job.flush     = bytes.last_byte && (cnt_rest != 5'd0);
		job.flush_div = (cnt_rest > 5'(b91_pkg::HALF_BITS))
			|| (rest > 13'(b91_pkg::FLUSH_LIMIT));
	end

	assign bytes.ready = !full;
	assign accept      = bytes.valid && !full;
	assign push        = accept && (take || bytes.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (bytes.last_byte) begin
				store_q <= '0;
				cnt_q   <= '0;
			end else begin
				store_q <= rest;
				cnt_q   <= cnt_rest[3:0];
			end
		end
	end

	`B91_ASSERT(a_cnt_range, cnt_q <= 4'(b91_pkg::TAKE_LIMIT), "held bit count above 13")
	`B91_ASSERT(a_store_clean, (store_q >> cnt_q) == 13'd0, "stray bits above held count")

endmodule
`default_nettype wire

@@ rtl/core/b91_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module b91_queue #(
	parameter int DEPTH = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  b91_pkg::b91_job_t wdata,
	output logic              full,
	output logic              head_valid,
	output b91_pkg::b91_job_t head,
	input  wire               pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b91_pkg::b91_job_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`B91_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`B91_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from empty queue")

endmodule
`default_nettype wire

@@ rtl/core/b91_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module b91_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               head_valid,
	input  b91_pkg::b91_job_t head,
	output logic              pop,
	b91_char_if.source        chars
);

	logic [3:0]      done_q;
	logic            out_valid_q;
	logic [6:0]      out_char_q;
	logic            last_char_q;

	logic [3:0]      mask;
	logic [3:0]      pending;
	logic [3:0]      sel;
	logic            final_char;
	logic            load;
	logic [13:0]     prod_v;
	logic [13:0]     diff_v;
	logic [12:0]     prod_f;
	logic [12:0]     diff_f;
	b91_pkg::sym_t   sym;

	always_comb begin
		mask       = {head.flush && head.flush_div, head.flush, head.pair, head.pair};
		pending    = mask & ~done_q;
		sel        = pending & (~pending + 4'd1);
		final_char = (pending & ~sel) == 4'd0;

		prod_v = 14'(head.qv) * 14'(b91_pkg::RADIX);
		diff_v = head.v - prod_v;
		prod_f = 13'(head.qf) * 13'(b91_pkg::RADIX);
		diff_f = head.f - prod_f;

		unique case (sel)
			4'b0001: sym = diff_v[6:0];
			4'b0010: sym = head.qv;
			4'b0100: sym = diff_f[6:0];
			4'b1000: sym = head.qf;
			default: sym = '0;
		endcase
	end

	assign load         = head_valid && (!out_valid_q || chars.ready);
	assign pop          = load && final_char;
	assign chars.valid     = out_valid_q;
	assign chars.out_char  = out_char_q;
	assign chars.last_char = last_char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= final_char ? 4'd0 : (done_q | sel);
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q  <= b91_pkg::char_of(sym);
			last_char_q <= head.last && final_char;
		end
	end

	`B91_ASSERT(a_done_subset, !head_valid || ((done_q & ~mask) == 4'd0),
		"consumed mask outside job")
	`B91_ASSERT(a_job_nonempty, !head_valid || (mask != 4'd0), "queued job with no characters")
	`B91_ASSERT_NEXT(a_pop_clears, pop, done_q == 4'd0, "consumed mask kept after pop")

endmodule
`default_nettype wire

@@ rtl/core/base91_byte_encoder.sv @@
// The first character of a byte is registered in the job queue and then in the output
// register before it shows on chars, with the job queue empty and chars ready.
// Throughput: one character per cycle from the output register while chars is ready;
// a byte is accepted each cycle while the job queue (QUEUE_DEPTH entries) has room.
// A byte gives up to two characters (four on the last byte); bytes queue up while
// characters drain. Reset (arst_n low, asynchronous): bit store, queue and output empty.
`default_nettype none
module base91_byte_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input wire         clk,
	input wire         arst_n,
	b91_byte_if.sink   bytes,
	b91_char_if.source chars
);

	logic              push;
	logic              full;
	logic              head_valid;
	logic              pop;
	b91_pkg::b91_job_t job;
	b91_pkg::b91_job_t head;

	b91_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.full   (full),
		.push   (push),
		.job    (job)
	);

	b91_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (job),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	b91_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.chars      (chars)
	);

endmodule
`default_nettype wire
